// File: hw/rtl/lli_pkg.sv
// Shared widths, result codes and queue payload types for the line-line
// intersection core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lli_pkg;

    // port width of each coordinate and of each crossing coordinate
    localparam int IN_W       = 12;
    localparam int OUT_W      = 58;

    // coordinates are taken from the low COORD_BITS bits of each port
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 20;

    localparam int DIFF_W  = COORD_BITS + 1;       // A and B coefficients
    localparam int PROD_W  = 2 * COORD_BITS;       // coordinate products
    localparam int C_W     = PROD_W + 1;           // C coefficient
    localparam int DET_P_W = 2 * DIFF_W;           // A*B products
    localparam int DET_W   = DET_P_W + 1;          // det
    localparam int DX_P_W  = DIFF_W + C_W;         // B*C and A*C products
    localparam int DETX_W  = DX_P_W + 1;           // det_x, det_y
    localparam int NUM_W   = DETX_W + FRAC_BITS;   // scaled dividend
    localparam int RES_W   = (NUM_W > OUT_W) ? NUM_W : OUT_W;

    localparam int MID_DEPTH = 2;
    localparam int MID_PTR_W = $clog2(MID_DEPTH);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

    typedef enum logic [1:0] {
        KIND_PARALLEL   = 2'd0,
        KIND_CROSS      = 2'd1,
        KIND_COINCIDENT = 2'd2
    } kind_t;

    // classified request handed from the front end to the divider
    typedef struct packed {
        kind_t              kind;
        logic               neg_x;
        logic               neg_y;
        logic [DET_W-1:0]   den;
        logic [DETX_W-1:0]  num_x;
        logic [DETX_W-1:0]  num_y;
    } work_t;

    typedef struct packed {
        kind_t             kind;
        logic [OUT_W-1:0]  x;
        logic [OUT_W-1:0]  y;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/lli_front.sv
// Front end: accepts line pairs, forms coefficients and Cramer determinants
// in four stages and classifies each pair. Depends on lli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lli_front (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                push,
    output logic                               full,
    input  wire  signed [lli_pkg::IN_W-1:0]    a_x,
    input  wire  signed [lli_pkg::IN_W-1:0]    a_y,
    input  wire  signed [lli_pkg::IN_W-1:0]    b_x,
    input  wire  signed [lli_pkg::IN_W-1:0]    b_y,
    input  wire  signed [lli_pkg::IN_W-1:0]    c_x,
    input  wire  signed [lli_pkg::IN_W-1:0]    c_y,
    input  wire  signed [lli_pkg::IN_W-1:0]    d_x,
    input  wire  signed [lli_pkg::IN_W-1:0]    d_y,
    output lli_pkg::work_t                     work,
    output logic                               work_push,
    input  wire                                work_full
);

    logic f_adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: coordinates
    logic signed [lli_pkg::COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [lli_pkg::COORD_BITS-1:0] cx_reg, cy_reg, dx_reg, dy_reg;

    // stage 2: coefficients and coordinate products
    logic signed [lli_pkg::DIFF_W-1:0] a1_next, b1_next, a2_next, b2_next;
    logic signed [lli_pkg::DIFF_W-1:0] a1_s2_reg, b1_s2_reg, a2_s2_reg, b2_s2_reg;
    logic signed [lli_pkg::PROD_W-1:0] p1a_next, p1b_next, p2a_next, p2b_next;
    logic signed [lli_pkg::PROD_W-1:0] p1a_reg, p1b_reg, p2a_reg, p2b_reg;

    // stage 3: C coefficients and det products
    logic signed [lli_pkg::DIFF_W-1:0] a1_s3_reg, b1_s3_reg, a2_s3_reg, b2_s3_reg;
    logic signed [lli_pkg::C_W-1:0]     c1_next, c2_next, c1_reg, c2_reg;
    logic signed [lli_pkg::DET_P_W-1:0] pd1_next, pd2_next, pd1_reg, pd2_reg;

    // stage 4: det and the sub-determinant products
    logic signed [lli_pkg::DET_W-1:0]  det_next, det_reg;
    logic signed [lli_pkg::DX_P_W-1:0] pbx1_next, pbx2_next, pay1_next, pay2_next;
    logic signed [lli_pkg::DX_P_W-1:0] pbx1_reg, pbx2_reg, pay1_reg, pay2_reg;

    logic signed [lli_pkg::DETX_W-1:0] detx, dety;

    // the whole front end holds while the queue to the divider is full
    assign f_adv = !work_full;
    assign full  = work_full;

    always_comb
    begin
        a1_next  = lli_pkg::DIFF_W'(by_reg) - lli_pkg::DIFF_W'(ay_reg);
        b1_next  = lli_pkg::DIFF_W'(ax_reg) - lli_pkg::DIFF_W'(bx_reg);
        a2_next  = lli_pkg::DIFF_W'(dy_reg) - lli_pkg::DIFF_W'(cy_reg);
        b2_next  = lli_pkg::DIFF_W'(cx_reg) - lli_pkg::DIFF_W'(dx_reg);
        // C1 = by*ax - bx*ay, C2 = dy*cx - dx*cy
        p1a_next = lli_pkg::PROD_W'(by_reg) * lli_pkg::PROD_W'(ax_reg);
        p1b_next = lli_pkg::PROD_W'(bx_reg) * lli_pkg::PROD_W'(ay_reg);
        p2a_next = lli_pkg::PROD_W'(dy_reg) * lli_pkg::PROD_W'(cx_reg);
        p2b_next = lli_pkg::PROD_W'(dx_reg) * lli_pkg::PROD_W'(cy_reg);

        c1_next  = lli_pkg::C_W'(p1a_reg) - lli_pkg::C_W'(p1b_reg);
        c2_next  = lli_pkg::C_W'(p2a_reg) - lli_pkg::C_W'(p2b_reg);
        pd1_next = lli_pkg::DET_P_W'(a1_s2_reg) * lli_pkg::DET_P_W'(b2_s2_reg);
        pd2_next = lli_pkg::DET_P_W'(b1_s2_reg) * lli_pkg::DET_P_W'(a2_s2_reg);

        det_next  = lli_pkg::DET_W'(pd1_reg) - lli_pkg::DET_W'(pd2_reg);
        pbx1_next = lli_pkg::DX_P_W'(b2_s3_reg) * lli_pkg::DX_P_W'(c1_reg);
        pbx2_next = lli_pkg::DX_P_W'(b1_s3_reg) * lli_pkg::DX_P_W'(c2_reg);
        pay1_next = lli_pkg::DX_P_W'(a1_s3_reg) * lli_pkg::DX_P_W'(c2_reg);
        pay2_next = lli_pkg::DX_P_W'(c1_reg) * lli_pkg::DX_P_W'(a2_s3_reg);
    end

    // finish det_x and det_y, classify and split off the signs
    always_comb
    begin
        detx = lli_pkg::DETX_W'(pbx1_reg) - lli_pkg::DETX_W'(pbx2_reg);
        dety = lli_pkg::DETX_W'(pay1_reg) - lli_pkg::DETX_W'(pay2_reg);

        if (det_reg != '0)
            work.kind = lli_pkg::KIND_CROSS;
        else if (detx == '0 && dety == '0)
            work.kind = lli_pkg::KIND_COINCIDENT;
        else
            work.kind = lli_pkg::KIND_PARALLEL;

        work.neg_x = detx[lli_pkg::DETX_W-1] ^ det_reg[lli_pkg::DET_W-1];
        work.neg_y = dety[lli_pkg::DETX_W-1] ^ det_reg[lli_pkg::DET_W-1];
        work.den   = det_reg[lli_pkg::DET_W-1] ? lli_pkg::DET_W'(-det_reg)
                                               : lli_pkg::DET_W'(det_reg);
        work.num_x = detx[lli_pkg::DETX_W-1] ? lli_pkg::DETX_W'(-detx)
                                             : lli_pkg::DETX_W'(detx);
        work.num_y = dety[lli_pkg::DETX_W-1] ? lli_pkg::DETX_W'(-dety)
                                             : lli_pkg::DETX_W'(dety);
    end

    assign work_push = v4_reg && f_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (f_adv)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            ax_reg <= a_x[lli_pkg::COORD_BITS-1:0];
            ay_reg <= a_y[lli_pkg::COORD_BITS-1:0];
            bx_reg <= b_x[lli_pkg::COORD_BITS-1:0];
            by_reg <= b_y[lli_pkg::COORD_BITS-1:0];
            cx_reg <= c_x[lli_pkg::COORD_BITS-1:0];
            cy_reg <= c_y[lli_pkg::COORD_BITS-1:0];
            dx_reg <= d_x[lli_pkg::COORD_BITS-1:0];
            dy_reg <= d_y[lli_pkg::COORD_BITS-1:0];

            a1_s2_reg <= a1_next;
            b1_s2_reg <= b1_next;
            a2_s2_reg <= a2_next;
            b2_s2_reg <= b2_next;
            p1a_reg   <= p1a_next;
            p1b_reg   <= p1b_next;
            p2a_reg   <= p2a_next;
            p2b_reg   <= p2b_next;

            a1_s3_reg <= a1_s2_reg;
            b1_s3_reg <= b1_s2_reg;
            a2_s3_reg <= a2_s2_reg;
            b2_s3_reg <= b2_s2_reg;
            c1_reg    <= c1_next;
            c2_reg    <= c2_next;
            pd1_reg   <= pd1_next;
            pd2_reg   <= pd2_next;

            det_reg  <= det_next;
            pbx1_reg <= pbx1_next;
            pbx2_reg <= pbx2_next;
            pay1_reg <= pay1_next;
            pay2_reg <= pay2_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lli_work_fifo.sv
// Short queue of classified requests between the front end and the divider.
// Depends on lli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lli_work_fifo (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  lli_pkg::work_t      din,
    output logic                full,
    input  wire                 pop,
    output lli_pkg::work_t      dout,
    output logic                empty
);

    lli_pkg::work_t                 mem_reg [lli_pkg::MID_DEPTH];
    logic [lli_pkg::MID_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [lli_pkg::MID_PTR_W:0]    count_reg;
    logic                           do_push, do_pop;

    assign full    = count_reg == (lli_pkg::MID_PTR_W + 1)'(lli_pkg::MID_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + lli_pkg::MID_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + lli_pkg::MID_PTR_W'(1);
            count_reg <= count_reg + (lli_pkg::MID_PTR_W + 1)'(do_push)
                                   - (lli_pkg::MID_PTR_W + 1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

`ifndef ASSERT_OFF
    a_mid_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (lli_pkg::MID_PTR_W + 1)'(lli_pkg::MID_DEPTH))
        else $error("work queue count exceeds depth");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/lli_back.sv
// Back end: pipelined restoring divider for both coordinates, rounding and
// sign restore. Depends on lli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lli_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  lli_pkg::work_t       work,
    input  wire                  work_empty,
    output logic                 work_pop,
    output lli_pkg::result_t     res,
    output logic                 res_push,
    input  wire                  res_full
);

    typedef struct packed {
        lli_pkg::kind_t                kind;
        logic                          neg_x;
        logic                          neg_y;
        logic [lli_pkg::DET_W-1:0]     den;
        logic [lli_pkg::DET_W-1:0]     rem_x;
        logic [lli_pkg::NUM_W-1:0]     nq_x;
        logic [lli_pkg::DET_W-1:0]     rem_y;
        logic [lli_pkg::NUM_W-1:0]     nq_y;
    } div_t;

    // one quotient bit per coordinate; dividend bits leave the top of nq
    // while quotient bits enter at the bottom
    function automatic div_t div_stage(input div_t s);
        logic [lli_pkg::DET_W:0] trial_x;
        logic [lli_pkg::DET_W:0] trial_y;
        div_t                    r;
        r       = s;
        trial_x = {s.rem_x, s.nq_x[lli_pkg::NUM_W-1]};
        trial_y = {s.rem_y, s.nq_y[lli_pkg::NUM_W-1]};
        r.nq_x  = {s.nq_x[lli_pkg::NUM_W-2:0], 1'b0};
        r.nq_y  = {s.nq_y[lli_pkg::NUM_W-2:0], 1'b0};
        if (trial_x >= {1'b0, s.den})
        begin
            r.rem_x   = lli_pkg::DET_W'(trial_x - {1'b0, s.den});
            r.nq_x[0] = 1'b1;
        end
        else
        begin
            r.rem_x = trial_x[lli_pkg::DET_W-1:0];
        end
        if (trial_y >= {1'b0, s.den})
        begin
            r.rem_y   = lli_pkg::DET_W'(trial_y - {1'b0, s.den});
            r.nq_y[0] = 1'b1;
        end
        else
        begin
            r.rem_y = trial_y[lli_pkg::DET_W-1:0];
        end
        return r;
    endfunction

    logic                          b_adv;
    div_t                          st_reg  [lli_pkg::NUM_W+1];
    div_t                          st_next [lli_pkg::NUM_W+1];
    logic [lli_pkg::NUM_W:0]       vld_reg;

    logic                          up_x, up_y;
    logic [lli_pkg::RES_W-1:0]     qr_x_next, qr_y_next;
    logic [lli_pkg::RES_W-1:0]     qr_x_reg, qr_y_reg;
    lli_pkg::kind_t                rnd_kind_reg;
    logic                          rnd_neg_x_reg, rnd_neg_y_reg;
    logic                          rnd_vld_reg;

    logic [lli_pkg::RES_W-1:0]     negq_x, negq_y;
    lli_pkg::result_t              res_next, res_reg;
    logic                          res_vld_reg;

    // the whole back end holds while the result queue is full
    assign b_adv    = !res_full;
    assign work_pop = b_adv && !work_empty;

    always_comb
    begin
        st_next[0].kind  = work.kind;
        st_next[0].neg_x = work.neg_x;
        st_next[0].neg_y = work.neg_y;
        st_next[0].den   = work.den;
        st_next[0].rem_x = '0;
        st_next[0].rem_y = '0;
        st_next[0].nq_x  = {work.num_x, {lli_pkg::FRAC_BITS{1'b0}}};
        st_next[0].nq_y  = {work.num_y, {lli_pkg::FRAC_BITS{1'b0}}};
        for (int i = 1; i <= lli_pkg::NUM_W; i++)
            st_next[i] = div_stage(st_reg[i-1]);
    end

    // round half away from zero: bump the magnitude when 2*rem >= den
    always_comb
    begin
        up_x      = {st_reg[lli_pkg::NUM_W].rem_x, 1'b0}
                    >= {1'b0, st_reg[lli_pkg::NUM_W].den};
        up_y      = {st_reg[lli_pkg::NUM_W].rem_y, 1'b0}
                    >= {1'b0, st_reg[lli_pkg::NUM_W].den};
        qr_x_next = lli_pkg::RES_W'(st_reg[lli_pkg::NUM_W].nq_x) + lli_pkg::RES_W'(up_x);
        qr_y_next = lli_pkg::RES_W'(st_reg[lli_pkg::NUM_W].nq_y) + lli_pkg::RES_W'(up_y);
    end

    always_comb
    begin
        negq_x        = ~qr_x_reg + lli_pkg::RES_W'(1);
        negq_y        = ~qr_y_reg + lli_pkg::RES_W'(1);
        res_next.kind = rnd_kind_reg;
        if (rnd_kind_reg == lli_pkg::KIND_CROSS)
        begin
            res_next.x = rnd_neg_x_reg ? negq_x[lli_pkg::OUT_W-1:0]
                                       : qr_x_reg[lli_pkg::OUT_W-1:0];
            res_next.y = rnd_neg_y_reg ? negq_y[lli_pkg::OUT_W-1:0]
                                       : qr_y_reg[lli_pkg::OUT_W-1:0];
        end
        else
        begin
            res_next.x = '0;
            res_next.y = '0;
        end
    end

    assign res      = res_reg;
    assign res_push = res_vld_reg && b_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rnd_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            vld_reg     <= {vld_reg[lli_pkg::NUM_W-1:0], work_pop};
            rnd_vld_reg <= vld_reg[lli_pkg::NUM_W];
            res_vld_reg <= rnd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            for (int i = 0; i <= lli_pkg::NUM_W; i++)
                st_reg[i] <= st_next[i];
            rnd_kind_reg  <= st_reg[lli_pkg::NUM_W].kind;
            rnd_neg_x_reg <= st_reg[lli_pkg::NUM_W].neg_x;
            rnd_neg_y_reg <= st_reg[lli_pkg::NUM_W].neg_y;
            qr_x_reg      <= qr_x_next;
            qr_y_reg      <= qr_y_next;
            res_reg       <= res_next;
        end
    end

`ifndef ASSERT_OFF
    a_cross_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && st_reg[0].kind == lli_pkg::KIND_CROSS |-> st_reg[0].den != '0)
        else $error("crossing request entered the divider with zero det");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[lli_pkg::NUM_W] && st_reg[lli_pkg::NUM_W].kind == lli_pkg::KIND_CROSS
        |-> st_reg[lli_pkg::NUM_W].rem_x < st_reg[lli_pkg::NUM_W].den
            && st_reg[lli_pkg::NUM_W].rem_y < st_reg[lli_pkg::NUM_W].den)
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/lli_result_fifo.sv
// Result queue in front of the output ports; parts the divider from the
// consumer. Depends on lli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lli_result_fifo (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  lli_pkg::result_t    din,
    output logic                full,
    input  wire                 pop,
    output lli_pkg::result_t    dout,
    output logic                empty
);

    lli_pkg::result_t               mem_reg [lli_pkg::OUT_DEPTH];
    logic [lli_pkg::OUT_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [lli_pkg::OUT_PTR_W:0]    count_reg;
    logic                           do_push, do_pop;

    assign full    = count_reg == (lli_pkg::OUT_PTR_W + 1)'(lli_pkg::OUT_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + lli_pkg::OUT_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + lli_pkg::OUT_PTR_W'(1);
            count_reg <= count_reg + (lli_pkg::OUT_PTR_W + 1)'(do_push)
                                   - (lli_pkg::OUT_PTR_W + 1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

`ifndef ASSERT_OFF
    a_out_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (lli_pkg::OUT_PTR_W + 1)'(lli_pkg::OUT_DEPTH))
        else $error("result queue count exceeds depth");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/line_line_intersection_core.sv
// Line-line intersection core: top level joining front end, request queue,
// divider back end and result queue. Depends on lli_pkg and all lli_ modules.
//
// Usage:
//   Input queue: drive the two points of each line on a_x..d_y and raise
//   push; a pair is taken on a rising edge with push high and full low.
//   Result queue: while empty is low, kind, cross_x and cross_y show the
//   oldest result; raise pop to take it. kind is 0 parallel, 1 single
//   crossing, 2 coincident; cross_x/cross_y carry FRAC_BITS fraction bits,
//   rounded half away from zero, and are zero unless kind is 1.
//   Throughput: one pair per cycle while full is low, set by the fully
//   pipelined divider (one quotient bit per stage for both coordinates).
//   Path from accept to result shown: four determinant stages, the request
//   queue, NUM_W + 1 divider stages, rounding, sign, result queue.
//   Reset clears all queues and valid flags; data registers are not reset.
//   When pop stays low the result queue fills, the divider then holds,
//   the two-entry request queue fills and full rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module line_line_intersection_core (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                push,
    output logic                               full,
    input  wire  signed [lli_pkg::IN_W-1:0]    a_x,
    input  wire  signed [lli_pkg::IN_W-1:0]    a_y,
    input  wire  signed [lli_pkg::IN_W-1:0]    b_x,
    input  wire  signed [lli_pkg::IN_W-1:0]    b_y,
    input  wire  signed [lli_pkg::IN_W-1:0]    c_x,
    input  wire  signed [lli_pkg::IN_W-1:0]    c_y,
    input  wire  signed [lli_pkg::IN_W-1:0]    d_x,
    input  wire  signed [lli_pkg::IN_W-1:0]    d_y,
    output logic                               empty,
    input  wire                                pop,
    output logic        [1:0]                  kind,
    output logic signed [lli_pkg::OUT_W-1:0]   cross_x,
    output logic signed [lli_pkg::OUT_W-1:0]   cross_y
);

    lli_pkg::work_t    work_in, work_out;
    logic              work_push, work_full, work_pop, work_empty;
    lli_pkg::result_t  res_in, res_head;
    logic              res_push, res_full;

    lli_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .a_x        (a_x),
        .a_y        (a_y),
        .b_x        (b_x),
        .b_y        (b_y),
        .c_x        (c_x),
        .c_y        (c_y),
        .d_x        (d_x),
        .d_y        (d_y),
        .work       (work_in),
        .work_push  (work_push),
        .work_full  (work_full)
    );

    lli_work_fifo u_work_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (work_push),
        .din    (work_in),
        .full   (work_full),
        .pop    (work_pop),
        .dout   (work_out),
        .empty  (work_empty)
    );

    lli_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .work        (work_out),
        .work_empty  (work_empty),
        .work_pop    (work_pop),
        .res         (res_in),
        .res_push    (res_push),
        .res_full    (res_full)
    );

    lli_result_fifo u_result_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_push),
        .din    (res_in),
        .full   (res_full),
        .pop    (pop),
        .dout   (res_head),
        .empty  (empty)
    );

    assign kind    = res_head.kind;
    assign cross_x = signed'(res_head.x);
    assign cross_y = signed'(res_head.y);

`ifndef ASSERT_OFF
    a_no_cross_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind != lli_pkg::KIND_CROSS |-> cross_x == '0 && cross_y == '0)
        else $error("non-crossing result with nonzero coordinates");
`endif

endmodule

`default_nettype wire
